// ===== hdl/adir_pkg.sv =====
// shared types, character codes and helpers for the ascii decimal integer reader
package adir_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int MAG_W               = 32;
  localparam int CH_W                = 8;

  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

  localparam logic SIGNED_MODE_RESET = 1'b1;

  // character held in the input register
  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] ch;
  } stage_t;

  // one result as it leaves the parser
  typedef struct packed {
    logic             accepted;
    logic             valid_res;
    logic             negative;
    logic [MAG_W-1:0] magnitude;
    logic             overflow;
  } result_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== hdl/adir_in_stage.sv =====
// input register: holds one character until the parser takes it
module adir_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [adir_pkg::CH_W-1:0]   ch,
  input  logic                        advance,
  output adir_pkg::stage_t            stage
);

  logic                      s1_valid;
  logic [adir_pkg::CH_W-1:0] s1_ch;
  logic                      load;

  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= load || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_ch <= ch;
    end
  end

  assign stage.valid = s1_valid;
  assign stage.ch    = s1_ch;

endmodule

// ===== hdl/adir_parse.sv =====
// parser state and the per-character step, plus the mode register
module adir_parse #(
  parameter int VALUE_WIDTH = adir_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  adir_pkg::stage_t   stage,
  input  logic               advance,
  output adir_pkg::result_t  result
);

  localparam int PW    = VALUE_WIDTH + 4;
  localparam int MAG_W = adir_pkg::MAG_W;

  logic                   signed_mode;
  logic                   in_number;
  logic                   minus_seen;
  logic [VALUE_WIDTH-1:0] accum;
  logic                   well_formed;
  logic                   overflowed;

  logic                   in_number_next;
  logic                   minus_seen_next;
  logic [VALUE_WIDTH-1:0] accum_next;
  logic                   well_formed_next;
  logic                   overflowed_next;
  logic                   accepted;

  logic                   c_space;
  logic                   c_digit;
  logic                   c_sign;
  logic                   start;
  logic                   minus_b;
  logic [VALUE_WIDTH-1:0] accum_b;
  logic                   wf_b;
  logic                   ovf_b;
  logic [PW-1:0]          accum_w;
  logic [PW-1:0]          prod;
  logic [3:0]             digit;
  logic                   step;

  assign cfg_ready = 1'b1;
  assign step      = stage.valid && advance;

  assign c_space = adir_pkg::is_space(stage.ch);
  assign c_digit = adir_pkg::is_digit(stage.ch);
  assign c_sign  = (stage.ch == adir_pkg::CH_PLUS) || (stage.ch == adir_pkg::CH_MINUS);
  assign start   = !in_number && !c_space;

  // a new number starts from cleared state
  assign minus_b = start ? 1'b0 : minus_seen;
  assign accum_b = start ? '0 : accum;
  assign wf_b    = start ? 1'b0 : well_formed;
  assign ovf_b   = start ? 1'b0 : overflowed;

  // times ten plus digit, top four bits catch the overflow
  assign digit   = 4'(stage.ch - adir_pkg::CH_ZERO);
  assign accum_w = PW'(accum_b);
  assign prod    = (accum_w << 3) + (accum_w << 1) + PW'(digit);

  always_comb begin
    in_number_next   = in_number;
    minus_seen_next  = minus_b;
    accum_next       = accum_b;
    well_formed_next = wf_b;
    overflowed_next  = ovf_b;
    accepted         = 1'b1;
    if (!in_number && c_space) begin
      // idle whitespace, state untouched
    end else if (start && signed_mode && c_sign) begin
      in_number_next  = 1'b1;
      minus_seen_next = (stage.ch == adir_pkg::CH_MINUS);
    end else if (c_digit) begin
      in_number_next   = 1'b1;
      accum_next       = prod[VALUE_WIDTH-1:0];
      well_formed_next = 1'b1;
      overflowed_next  = ovf_b || (|prod[PW-1:VALUE_WIDTH]);
    end else begin
      in_number_next = 1'b0;
      accepted       = 1'b0;
      if (!c_space) begin
        well_formed_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= adir_pkg::SIGNED_MODE_RESET;
      in_number   <= 1'b0;
      minus_seen  <= 1'b0;
      accum       <= '0;
      well_formed <= 1'b0;
      overflowed  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        signed_mode <= cfg_data;
      end
      if (step) begin
        in_number   <= in_number_next;
        minus_seen  <= minus_seen_next;
        accum       <= accum_next;
        well_formed <= well_formed_next;
        overflowed  <= overflowed_next;
      end
    end
  end

  assign result.accepted  = accepted;
  assign result.valid_res = well_formed_next;
  assign result.negative  = minus_seen_next;
  assign result.magnitude = MAG_W'(accum_next);
  assign result.overflow  = overflowed_next;

endmodule

// ===== hdl/adir_out_stage.sv =====
// result register with valid and stall toward the consumer
module adir_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               take_valid,
  input  adir_pkg::result_t  result,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_stall,
  output adir_pkg::result_t  out_res
);

  logic              held;
  adir_pkg::result_t res;

  assign advance = !held || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (advance) begin
      held <= take_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take_valid) begin
      res <= result;
    end
  end

  assign out_valid = held;
  assign out_res   = res;

endmodule

// ===== hdl/ascii_decimal_integer_reader_core.sv =====
// top level of the ascii decimal integer reader
// a character is held in the input register, stepped by the parser and then registered
//   in the result register, which drives the outputs
// throughput: one character per cycle while the consumer does not stall, set by the single
//   register-to-register step, a sum of two shifted accumulator copies and the digit
// reset: synchronous; clears parser state and both register valid flags, signed mode returns to 1
module ascii_decimal_integer_reader_core #(
  parameter int VALUE_WIDTH = adir_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [adir_pkg::CH_W-1:0] ch,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      accepted,
  output logic                      valid_res,
  output logic                      negative,
  output logic [adir_pkg::MAG_W-1:0] magnitude,
  output logic                      overflow,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_data
);

  adir_pkg::stage_t  stage;
  adir_pkg::result_t result;
  adir_pkg::result_t out_res;
  logic              advance;

  adir_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ch       (ch),
    .advance  (advance),
    .stage    (stage)
  );

  adir_parse #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .advance   (advance),
    .result    (result)
  );

  adir_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .take_valid (stage.valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign accepted  = out_res.accepted;
  assign valid_res = out_res.valid_res;
  assign negative  = out_res.negative;
  assign magnitude = out_res.magnitude;
  assign overflow  = out_res.overflow;

endmodule

// ===== hdl/adir_checker.sv =====
// port-level checks for the ascii decimal integer reader, bound to the top level
module adir_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [adir_pkg::MAG_W-1:0] magnitude,
  input logic                       accepted
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(magnitude) && $stable(accepted))
    else $error("stalled result changed");

  // input side only stalls when the output side is backed up
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled with output free");

  // an accepted request reaches the outputs once the result register can take it
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !(out_valid && out_stall) |=> out_valid)
    else $error("result missing after request");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind ascii_decimal_integer_reader_core adir_checker u_adir_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .magnitude (magnitude),
  .accepted  (accepted)
);
